FILE: hdl/trapezoid_grid_integrator_3d_core_defines.svh
// ----------------------------------------------------------------------------
// Trapezoid grid integrator assertion macros
// Concurrent check wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_GRID_INTEGRATOR_3D_CORE_DEFINES_SVH
`define TRAPEZOID_GRID_INTEGRATOR_3D_CORE_DEFINES_SVH

`ifndef SYNTH
// antecedent and consequent in the same cycle
`define TGI3D_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tgi3d check failed");
// consequent in the cycle after the antecedent
`define TGI3D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tgi3d check failed");
`else
`define TGI3D_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TGI3D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/tgi3d_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoid grid integrator package
// Widths and the hand-off structure shared by the accumulator and finisher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tgi3d_pkg;

  localparam int N_W      = 8;    // divisions register width
  localparam int SMP_W    = 32;   // sample width
  localparam int SPAN_W   = 32;   // span width
  localparam int SUM_W    = 64;   // accumulator width
  localparam int LIMB_W   = 32;
  localparam int LIMBS    = 5;    // 64 + 3 * 31 bits of product fit in five limbs
  localparam int PROD_W   = LIMB_W * LIMBS;
  localparam int N3_W     = 3 * N_W;
  localparam int RND_LSB  = 50;   // scale is 2^51, one extra bit kept for rounding
  localparam int HI_LSB   = RND_LSB + SUM_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DIVISIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_Z    = 2'd3;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // last grid point reached: sum and overflow handed to the finisher
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
    logic             ovf;
  } tgi3d_load_t;

endpackage

`default_nettype wire

FILE: hdl/trapezoid_grid_integrator_3d_core.sv
// ----------------------------------------------------------------------------
// Trapezoid grid integrator, 3-D
// Composite trapezoid rule over an n x n x n grid with saturating Q48.16 out.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    in_sample
//   out      source     out_valid / out_ready  out_integral, out_saturated
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample per cycle while no integral is being finished.
// After the last grid point the finisher forms n^3 on the shared multiplier,
// makes three span passes over five limbs, divides bit-serially by n^3 and
// rounds; in_ready is low meanwhile.
// The finisher holds in its last step while a previous result is not taken.
// Reset is synchronous; configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "trapezoid_grid_integrator_3d_core_defines.svh"

module trapezoid_grid_integrator_3d_core #(
  parameter int MAX_DIVISIONS = 255
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [tgi3d_pkg::SMP_W-1:0]      in_sample,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [tgi3d_pkg::SUM_W-1:0]      out_integral,
  output logic                                  out_saturated,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tgi3d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tgi3d_pkg::SPAN_W-1:0]     cfg_data
);
  import tgi3d_pkg::*;

  localparam logic [N_W-1:0] N_CAP =
    (MAX_DIVISIONS >= (1 << N_W) - 1) ? {N_W{1'b1}} : N_W'(MAX_DIVISIONS);

  logic [N_W-1:0]    divisions_r;
  logic [SPAN_W-1:0] span_x_r, span_y_r, span_z_r;
  logic [N_W-1:0]    grid_n;
  logic              in_accept;
  logic              busy;
  tgi3d_load_t       load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisions_r <= N_W'(1);
      span_x_r    <= SPAN_W'(65536);
      span_y_r    <= SPAN_W'(65536);
      span_z_r    <= SPAN_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIVISIONS: divisions_r <= cfg_data[N_W-1:0];
        REG_SPAN_X:    span_x_r    <= cfg_data;
        REG_SPAN_Y:    span_y_r    <= cfg_data;
        REG_SPAN_Z:    span_z_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // zero intervals count as one
  assign grid_n = (divisions_r == '0) ? N_W'(1) :
                  ((divisions_r > N_CAP) ? N_CAP : divisions_r);

  assign in_ready  = !busy;
  assign in_accept = in_valid && in_ready;

  tgi3d_acc u_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .sample (in_sample),
    .grid_n (grid_n),
    .load   (load)
  );

  tgi3d_fin u_fin (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .grid_n        (grid_n),
    .span_x        (span_x_r),
    .span_y        (span_y_r),
    .span_z        (span_z_r),
    .out_ready     (out_ready),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_integral  (out_integral),
    .out_saturated (out_saturated)
  );

  `TGI3D_ASSERT_NEXT(a_last_blocks_input, clk, rst_n, load.start, !in_ready)
  `TGI3D_ASSERT_NEXT(a_result_needs_finish, clk, rst_n, !busy && !out_valid, !out_valid)
  `TGI3D_ASSERT_SAME(a_finish_gives_result, clk, rst_n, $fell(busy), out_valid)
  `TGI3D_ASSERT_SAME(a_start_only_on_accept, clk, rst_n, load.start, in_accept)

endmodule

`default_nettype wire

FILE: hdl/tgi3d_mac.sv
// ----------------------------------------------------------------------------
// Trapezoid grid integrator multiply-add
// Shared 32x32 unsigned multiplier with a 64-bit addend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgi3d_mac (
  input  wire logic [tgi3d_pkg::LIMB_W-1:0]   a,
  input  wire logic [tgi3d_pkg::LIMB_W-1:0]   b,
  input  wire logic [2*tgi3d_pkg::LIMB_W-1:0] c,
  output logic      [2*tgi3d_pkg::LIMB_W-1:0] t
);
  import tgi3d_pkg::*;

  logic [2*LIMB_W-1:0] prod;

  assign prod = {{LIMB_W{1'b0}}, a} * {{LIMB_W{1'b0}}, b};
  assign t    = prod + c;

endmodule

`default_nettype wire

FILE: hdl/tgi3d_acc.sv
// ----------------------------------------------------------------------------
// Trapezoid grid integrator accumulator
// Walks the grid indices and adds border-weighted samples with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgi3d_acc (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [tgi3d_pkg::SMP_W-1:0]   sample,
  input  wire logic [tgi3d_pkg::N_W-1:0]     grid_n,
  output tgi3d_pkg::tgi3d_load_t             load
);
  import tgi3d_pkg::*;

  logic [N_W-1:0]   ix_r, iy_r, iz_r;
  logic [N_W-1:0]   ix_nxt, iy_nxt, iz_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             ovf_r, ovf_nxt;

  logic             ex, ey, ez;
  logic [1:0]       nb;
  logic [SUM_W-1:0] smp_ext, term, raw_sum, acc_sum;
  logic             clip, last_pt;

  assign ex = (ix_r == '0) || (ix_r >= grid_n);
  assign ey = (iy_r == '0) || (iy_r >= grid_n);
  assign ez = (iz_r == '0) || (iz_r >= grid_n);
  assign nb = 2'(ex) + 2'(ey) + 2'(ez);

  assign smp_ext = {{(SUM_W-SMP_W){sample[SMP_W-1]}}, sample};

  // weight 2^(3 - border axes)
  always_comb begin
    case (nb)
      2'd0:    term = smp_ext << 3;
      2'd1:    term = smp_ext << 2;
      2'd2:    term = smp_ext << 1;
      default: term = smp_ext;
    endcase
  end

  assign raw_sum = sum_r + term;
  assign clip    = (sum_r[SUM_W-1] == term[SUM_W-1]) &&
                   (raw_sum[SUM_W-1] != sum_r[SUM_W-1]);
  assign acc_sum = clip ? (sum_r[SUM_W-1] ? SUM_MIN : SUM_MAX) : raw_sum;

  assign last_pt = (ix_r >= grid_n) && (iy_r >= grid_n) && (iz_r >= grid_n);

  always_comb begin
    ix_nxt  = ix_r;
    iy_nxt  = iy_r;
    iz_nxt  = iz_r;
    sum_nxt = sum_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      if (ix_r < grid_n) begin
        ix_nxt = ix_r + 1'b1;
      end else begin
        ix_nxt = '0;
        if (iy_r < grid_n) begin
          iy_nxt = iy_r + 1'b1;
        end else begin
          iy_nxt = '0;
          if (iz_r < grid_n) begin
            iz_nxt = iz_r + 1'b1;
          end else begin
            iz_nxt = '0;
          end
        end
      end
      // clear on the last point, the finisher takes the total
      sum_nxt = last_pt ? '0 : acc_sum;
      ovf_nxt = last_pt ? 1'b0 : (ovf_r | clip);
    end
  end

  assign load.start = accept && last_pt;
  assign load.sum   = acc_sum;
  assign load.ovf   = ovf_r | clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ix_r  <= '0;
      iy_r  <= '0;
      iz_r  <= '0;
      sum_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      ix_r  <= ix_nxt;
      iy_r  <= iy_nxt;
      iz_r  <= iz_nxt;
      sum_r <= sum_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tgi3d_fin.sv
// ----------------------------------------------------------------------------
// Trapezoid grid integrator finisher
// Scales the sum by the spans over the shared multiplier, divides by n^3
// bit-serially, rounds, saturates and holds the result for the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tgi3d_fin (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tgi3d_pkg::tgi3d_load_t         load,
  input  wire logic [tgi3d_pkg::N_W-1:0]      grid_n,
  input  wire logic [tgi3d_pkg::SPAN_W-1:0]   span_x,
  input  wire logic [tgi3d_pkg::SPAN_W-1:0]   span_y,
  input  wire logic [tgi3d_pkg::SPAN_W-1:0]   span_z,
  input  wire logic                           out_ready,
  output logic                                busy,
  output logic                                out_valid,
  output logic      [tgi3d_pkg::SUM_W-1:0]    out_integral,
  output logic                                out_saturated
);
  import tgi3d_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NSQ  = 3'd1;
  localparam logic [2:0] S_NCU  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_RND  = 3'd5;

  localparam logic [2:0] LAST_LIMB = 3'(LIMBS - 1);
  localparam logic [7:0] LAST_BIT  = 8'(PROD_W - 1);

  logic [2:0]          state_r, state_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [1:0]          pass_r, pass_nxt;
  logic [7:0]          bit_r, bit_nxt;
  logic [PROD_W-1:0]   v_r, v_nxt;
  logic [LIMB_W-1:0]   carry_r, carry_nxt;
  logic [N3_W-1:0]     n3_r, n3_nxt;
  logic [N3_W-1:0]     rem_r, rem_nxt;
  logic                neg_r, neg_nxt;
  logic                clip_r, clip_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]    out_integral_r, out_integral_nxt;
  logic                out_saturated_r, out_saturated_nxt;

  logic [LIMB_W-1:0]   mac_a, mac_b;
  logic [2*LIMB_W-1:0] mac_c, mac_t;
  logic [SPAN_W-1:0]   span_sel, span_mag;
  logic [SUM_W-1:0]    sum_mag;
  logic [N3_W:0]       rem_sh;
  logic                q_bit;
  logic                hi_nz;
  logic [SUM_W-1:0]    w, mag;
  logic                out_free;

  tgi3d_mac u_mac (
    .a (mac_a),
    .b (mac_b),
    .c (mac_c),
    .t (mac_t)
  );

  always_comb begin
    case (pass_r)
      2'd0:    span_sel = span_x;
      2'd1:    span_sel = span_y;
      default: span_sel = span_z;
    endcase
  end
  assign span_mag = span_sel[SPAN_W-1] ? ('0 - span_sel) : span_sel;
  assign sum_mag  = load.sum[SUM_W-1] ? ('0 - load.sum) : load.sum;

  // restoring division step
  assign rem_sh = {rem_r, v_r[PROD_W-1]};
  assign q_bit  = rem_sh >= {1'b0, n3_r};

  // drop 50 bits, then round the last one away from zero
  assign hi_nz = |v_r[PROD_W-1:HI_LSB];
  assign w     = v_r[HI_LSB-1:RND_LSB];
  assign mag   = {1'b0, w[SUM_W-1:1]} + {{(SUM_W-1){1'b0}}, w[0]};

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    unique case (state_r)
      S_NSQ: begin
        mac_a = {{(LIMB_W-N_W){1'b0}}, grid_n};
        mac_b = {{(LIMB_W-N_W){1'b0}}, grid_n};
      end
      S_NCU: begin
        mac_a = {{(LIMB_W-N3_W){1'b0}}, n3_r};
        mac_b = {{(LIMB_W-N_W){1'b0}}, grid_n};
      end
      S_MUL: begin
        mac_a = v_r[LIMB_W-1:0];
        mac_b = span_mag;
        mac_c = {{LIMB_W{1'b0}}, carry_r};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    pass_nxt          = pass_r;
    bit_nxt           = bit_r;
    v_nxt             = v_r;
    carry_nxt         = carry_r;
    n3_nxt            = n3_r;
    rem_nxt           = rem_r;
    neg_nxt           = neg_r;
    clip_nxt          = clip_r;
    out_integral_nxt  = out_integral_r;
    out_saturated_nxt = out_saturated_r;
    out_valid_nxt     = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (load.start) begin
          v_nxt     = {{(PROD_W-SUM_W){1'b0}}, sum_mag};
          neg_nxt   = load.sum[SUM_W-1] ^ span_x[SPAN_W-1] ^
                      span_y[SPAN_W-1] ^ span_z[SPAN_W-1];
          clip_nxt  = load.ovf;
          state_nxt = S_NSQ;
        end
      end
      S_NSQ: begin
        n3_nxt    = mac_t[N3_W-1:0];
        state_nxt = S_NCU;
      end
      S_NCU: begin
        n3_nxt    = mac_t[N3_W-1:0];
        cnt_nxt   = '0;
        pass_nxt  = '0;
        carry_nxt = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // rotate limbs through the multiplier, low limb first
        v_nxt     = {mac_t[LIMB_W-1:0], v_r[PROD_W-1:LIMB_W]};
        carry_nxt = mac_t[2*LIMB_W-1:LIMB_W];
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_LIMB) begin
          cnt_nxt   = '0;
          carry_nxt = '0;
          pass_nxt  = pass_r + 1'b1;
          if (pass_r == 2'd2) begin
            bit_nxt   = '0;
            rem_nxt   = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = q_bit ? N3_W'(rem_sh - {1'b0, n3_r}) : rem_sh[N3_W-1:0];
        v_nxt   = {v_r[PROD_W-2:0], q_bit};
        bit_nxt = bit_r + 1'b1;
        if (bit_r == LAST_BIT) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (hi_nz) begin
            out_integral_nxt  = neg_r ? SUM_MIN : SUM_MAX;
            out_saturated_nxt = 1'b1;
          end else if (neg_r) begin
            out_integral_nxt  = '0 - mag;
            out_saturated_nxt = clip_r;
          end else if (mag[SUM_W-1]) begin
            out_integral_nxt  = SUM_MAX;
            out_saturated_nxt = 1'b1;
          end else begin
            out_integral_nxt  = mag;
            out_saturated_nxt = clip_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r           <= cnt_nxt;
    pass_r          <= pass_nxt;
    bit_r           <= bit_nxt;
    v_r             <= v_nxt;
    carry_r         <= carry_nxt;
    n3_r            <= n3_nxt;
    rem_r           <= rem_nxt;
    neg_r           <= neg_nxt;
    clip_r          <= clip_nxt;
    out_integral_r  <= out_integral_nxt;
    out_saturated_r <= out_saturated_nxt;
  end

  assign busy          = state_r != S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_integral  = out_integral_r;
  assign out_saturated = out_saturated_r;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Trapezoid grid integrator testbench
// Streams grids of samples through the core under random idling on both
// channels. A cycle-level predictor of the weighted sum and the final scaling
// produces the expected integral for every completed grid. Each integral the
// core returns is checked against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tgi3d_pkg::*;

  localparam int MAX_DIV       = 255;
  localparam int SETTLE_CYCLES = 200;   // long enough for the finisher to run
  localparam int HOLD_CYCLES   = 1500;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ITEM_TARGET   = 940;

  localparam logic [SMP_W-1:0] CORNER_SAMPLES [8] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001
  };

  typedef struct packed {
    logic [SUM_W-1:0] integral;
    logic             saturated;
  } integral_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SMP_W-1:0]     in_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SUM_W-1:0]     out_integral;
  logic                 out_saturated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DIVISIONS;
  logic [SPAN_W-1:0]    cfg_data = '0;

  // predictor copy of the registers and the accumulator
  logic [N_W-1:0]    cfg_divisions = 8'd1;
  logic [SPAN_W-1:0] cfg_span_x = 32'd65536;
  logic [SPAN_W-1:0] cfg_span_y = 32'd65536;
  logic [SPAN_W-1:0] cfg_span_z = 32'd65536;
  logic [N_W-1:0]    grid_x = '0;
  logic [N_W-1:0]    grid_y = '0;
  logic [N_W-1:0]    grid_z = '0;
  logic [SUM_W-1:0]  acc_sum = '0;
  logic              acc_clipped = 1'b0;

  logic [SMP_W-1:0] pending_samples[$];
  integral_t        expected_integrals[$];
  integral_t        want;

  logic tx_idle = 1'b0;
  logic rx_idle = 1'b0;
  logic hold_on = 1'b0;
  int   hold_count = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   cycle_count = 0;
  int   samples_queued = 0;
  int   samples_taken = 0;
  int   integrals_seen = 0;
  int   reg_writes = 0;
  int   mismatch_count = 0;

  trapezoid_grid_integrator_3d_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_integral  (out_integral),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int grid_size();
    int n;
    n = cfg_divisions;
    if (n < 1) n = 1;
    if (n > MAX_DIV) n = MAX_DIV;
    return n;
  endfunction

  function automatic logic [31:0] magnitude32(logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  // sum * spans / (8 * 2^48 * n^3), rounded half away from zero
  function automatic integral_t scale_integral();
    logic [255:0]     prod;
    logic [SUM_W-1:0] mag_sum;
    logic [SUM_W-1:0] w;
    logic [SUM_W-1:0] m;
    logic             neg;
    integral_t        r;
    int               n;
    n = grid_size();
    neg = acc_sum[SUM_W-1] ^ cfg_span_x[31] ^ cfg_span_y[31] ^ cfg_span_z[31];
    mag_sum = acc_sum[SUM_W-1] ? -acc_sum : acc_sum;
    prod = 256'(mag_sum);
    prod = prod * 256'(magnitude32(cfg_span_x));
    prod = prod * 256'(magnitude32(cfg_span_y));
    prod = prod * 256'(magnitude32(cfg_span_z));
    prod = prod / 256'(n * n * n);
    prod = prod >> RND_LSB;
    r.saturated = acc_clipped;
    if (|prod[255:SUM_W]) begin
      r.saturated = 1'b1;
      r.integral = neg ? SUM_MIN : SUM_MAX;
    end else begin
      w = prod[SUM_W-1:0];
      m = (w >> 1) + {63'b0, w[0]};
      if (neg) begin
        r.integral = -m;
      end else if (m > SUM_MAX) begin
        r.integral = SUM_MAX;
        r.saturated = 1'b1;
      end else begin
        r.integral = m;
      end
    end
    return r;
  endfunction

  function automatic void accumulate_sample(logic [SMP_W-1:0] raw);
    int               n;
    int               borders;
    logic [SUM_W-1:0] term;
    logic [SUM_W-1:0] total;
    n = grid_size();
    borders = int'(grid_x == 0 || grid_x >= n) + int'(grid_y == 0 || grid_y >= n)
            + int'(grid_z == 0 || grid_z >= n);
    term = {{32{raw[31]}}, raw} << (3 - borders);
    total = acc_sum + term;
    if (acc_sum[SUM_W-1] == term[SUM_W-1] && total[SUM_W-1] != acc_sum[SUM_W-1]) begin
      acc_clipped = 1'b1;
      total = acc_sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end
    acc_sum = total;
    if (grid_x < n) begin
      grid_x++;
    end else begin
      grid_x = '0;
      if (grid_y < n) begin
        grid_y++;
      end else begin
        grid_y = '0;
        if (grid_z < n) begin
          grid_z++;
        end else begin
          grid_z = '0;
          expected_integrals.push_back(scale_integral());
          acc_sum = '0;
          acc_clipped = 1'b0;
        end
      end
    end
  endfunction

  // samples still needed to close the current grid
  function automatic int points_left();
    int n;
    int x;
    int y;
    int z;
    int count;
    bit done;
    n = grid_size();
    x = grid_x;
    y = grid_y;
    z = grid_z;
    count = 0;
    done = 1'b0;
    while (!done) begin
      count++;
      if (x < n) begin
        x++;
      end else begin
        x = 0;
        if (y < n) begin
          y++;
        end else begin
          y = 0;
          if (z < n) z++;
          else done = 1'b1;
        end
      end
    end
    return count;
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [SPAN_W-1:0] pick_span();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      4: return 32'hFFFF_0000;
      5, 6: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  // mostly tiny grids; larger ones now and then
  function automatic logic [SPAN_W-1:0] pick_divisions();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'd0;
    if (r <= 10) return 32'd1;
    if (r <= 15) return 32'd2;
    if (r <= 17) return 32'd3;
    if (r == 18) return 32'd4;
    return 32'($urandom_range(5, 6));
  endfunction

  task automatic queue_samples(int count);
    repeat (count) pending_samples.push_back(pick_sample());
    samples_queued += count;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_integrals.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPAN_W-1:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_DIVISIONS: cfg_divisions = data[N_W-1:0];
      REG_SPAN_X:    cfg_span_x = data;
      REG_SPAN_Y:    cfg_span_y = data;
      REG_SPAN_Z:    cfg_span_z = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_sample(in_sample);
        samples_taken++;
      end
      // hold an untaken request as it is
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          in_valid <= 1'b0;
          tx_gap--;
        end else if (pending_samples.size() != 0) begin
          in_sample <= pending_samples.pop_front();
          in_valid <= 1'b1;
          tx_gap = tx_idle ? $urandom_range(0, 8) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        integrals_seen++;
        if (expected_integrals.size() == 0) begin
          $error("integral: none expected, got %h", out_integral);
          mismatch_count++;
        end else begin
          want = expected_integrals.pop_front();
          if (out_integral !== want.integral) begin
            $error("integral: expected %h, got %h", want.integral, out_integral);
            mismatch_count++;
          end
          if (out_saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, out_saturated);
            mismatch_count++;
          end
        end
        rx_gap = rx_idle ? $urandom_range(0, 8) : 0;
      end
      if (hold_on) begin
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        out_ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // long receiver stall
  always @(posedge clk) begin
    if (hold_on) begin
      if (hold_count == HOLD_CYCLES) begin
        hold_on <= 1'b0;
        hold_count = 0;
      end else begin
        hold_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("trapezoid_grid_integrator_3d_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int points;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration, corner samples
    foreach (CORNER_SAMPLES[k]) pending_samples.push_back(CORNER_SAMPLES[k]);
    samples_queued += 8;
    wait_drained();

    // zero divisions with junk upper bits, extreme spans, full-scale samples
    write_reg(REG_DIVISIONS, 32'hABCD_EF00);
    write_reg(REG_SPAN_X, 32'h8000_0000);
    write_reg(REG_SPAN_Y, 32'h7FFF_FFFF);
    write_reg(REG_SPAN_Z, 32'h7FFF_FFFF);
    repeat (8) pending_samples.push_back(32'h7FFF_FFFF);
    samples_queued += 8;
    wait_drained();

    // largest grid, then shrink it and change a span before the grid closes
    write_reg(REG_DIVISIONS, 32'd255);
    queue_samples(3);
    wait_drained();
    write_reg(REG_DIVISIONS, 32'd1);
    write_reg(REG_SPAN_X, 32'hFFFF_0000);
    queue_samples(points_left());
    wait_drained();

    // stall the output while grids keep coming so the input backs up
    write_reg(REG_SPAN_X, pick_span());
    write_reg(REG_SPAN_Y, 32'h0001_0000);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_on <= 1'b1;
    queue_samples(32);
    wait_drained();

    while (samples_queued < ITEM_TARGET) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 1) == 0) begin
        wait_drained();
        write_reg(REG_DIVISIONS, ($urandom() & 32'hFFFF_FF00) | pick_divisions());
        if ($urandom_range(0, 1) == 0) write_reg(REG_SPAN_X, pick_span());
        if ($urandom_range(0, 1) == 0) write_reg(REG_SPAN_Y, pick_span());
        if ($urandom_range(0, 1) == 0) write_reg(REG_SPAN_Z, pick_span());
      end
      points = (grid_size() + 1) ** 3;
      if ($urandom_range(0, 5) == 0) begin
        // reconfigure partway through a grid
        queue_samples($urandom_range(1, points - 1));
        wait_drained();
        case ($urandom_range(0, 3))
          0: write_reg(REG_DIVISIONS, pick_divisions());
          1: write_reg(REG_SPAN_X, pick_span());
          2: write_reg(REG_SPAN_Y, pick_span());
          default: write_reg(REG_SPAN_Z, pick_span());
        endcase
        queue_samples(points_left());
      end else begin
        queue_samples(points);
      end
    end

    wait_drained();
    $display("%0d samples over %0d integrals, %0d register writes", samples_taken,
             integrals_seen, reg_writes);
    $display("included saturating spans, mid-grid reconfiguration and a long output stall");
    if (mismatch_count == 0) begin
      $display("trapezoid_grid_integrator_3d_core: match");
    end else begin
      $display("trapezoid_grid_integrator_3d_core: mismatch");
    end
    $finish;
  end

endmodule
